// ===== rtl/core/rsgt_pkg.sv =====
// Package for the random sampling gate tracker: shared constants, register
// indexes and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package rsgt_pkg;

    // Default sizes of the ADC reading and of the fixed-point gate fraction.
    localparam int ADC_BITS_DEF       = 12;
    localparam int GATE_FRAC_BITS_DEF = 8;

    // Fixed widths of the configuration fields and the shift result.
    localparam int COUNT_W   = 16;
    localparam int FACTOR_W  = 6;
    localparam int SHIFT_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Compare width for the acceptance window, wide enough for ADC sizes up to 17 bits.
    localparam int CMP_W = 17;

    localparam int ACCEPT_LOW       = 500;
    localparam int ACCEPT_HIGH      = 4000;
    localparam int HIGH_GATE_MARGIN = 50;
    localparam int BLEND_DIVISOR    = 5;
    localparam int BLEND_ROUND      = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MEASURES_PER_GATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_FACTOR     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOMIZE_ENABLE  = 2'd2;

    // Register reset values.
    localparam logic [COUNT_W-1:0]  MEASURES_RESET  = 16'd1000;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET    = 6'd50;
    localparam logic                RANDOMIZE_RESET = 1'b0;

    typedef enum logic {
        BLEND_SEL_MIN,
        BLEND_SEL_MAX
    } rsgt_blend_sel_t;

    typedef struct packed {
        logic            capture;      // load the incoming reading
        logic            res_clear;    // clear shift result at item start
        logic            reject;       // reading outside acceptance window
        logic            win_update;   // count and track running min/max
        logic            win_latch;    // latch first gates and restart window
        logic            win_blend;    // save window extremes and restart window
        logic            first_gates;  // use running min/max as the gates
        logic            gates_load;   // derive gates from the fixed-point gates
        logic            div_start;
        rsgt_blend_sel_t blend_sel;
        logic            blend_load;   // register the blend sum of the selected gate
        logic            gmin_write;
        logic            gmax_write;
        logic            res_write;    // store a valid shift
        logic            out_load;     // move the result into the output register
    } rsgt_cmd_t;

    typedef struct packed {
        logic rejected;
        logic learned;
        logic at_limit;
        logic shift_ok;
        logic div_done;
        logic out_free;
    } rsgt_stat_t;

endpackage

// ===== rtl/core/rsgt_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module rsgt_div #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    trial;

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial     = rem_shift - {1'b0, dvs_reg};
    assign done      = busy_reg && (cnt_reg == '0);
    assign quotient  = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg && (cnt_reg != '0)) begin
            // A clear borrow bit means the divisor fits into the partial remainder.
            if (!trial[DIVISOR_W]) begin
                rem_reg <= trial[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== rtl/core/rsgt_datapath.sv =====
// Datapath of the gate tracker: configuration registers, window and gate
// state, result staging, output register, gate blend and the shift divider.
// Depends on rsgt_pkg and rsgt_div.
`timescale 1ns / 1ps

module rsgt_datapath #(
    parameter int ADC_BITS       = rsgt_pkg::ADC_BITS_DEF,
    parameter int GATE_FRAC_BITS = rsgt_pkg::GATE_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rsgt_pkg::rsgt_cmd_t                 cmd,
    output rsgt_pkg::rsgt_stat_t                stat,
    input  logic                                cfg_write,
    input  logic [rsgt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rsgt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [ADC_BITS-1:0]                 s_adc_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_shift_valid,
    output logic [rsgt_pkg::SHIFT_W-1:0]        m_shift,
    output logic [ADC_BITS-1:0]                 m_gate_low,
    output logic [ADC_BITS-1:0]                 m_gate_high
);

    import rsgt_pkg::*;

    localparam int FIXED_W     = ADC_BITS + GATE_FRAC_BITS;
    localparam int SUM_W       = FIXED_W + 3;
    localparam int RECIP_SHIFT = SUM_W + 2;
    localparam int BPROD_W     = SUM_W + RECIP_SHIFT;
    localparam int PROD_W      = ADC_BITS + FACTOR_W;

    // The reciprocal is rounded up; its error is small enough that the product
    // gives the exact floor of the division by five for every blend sum.
    localparam logic [RECIP_SHIFT-1:0] BLEND_RECIP = RECIP_SHIFT'(
        ((64'd1 << RECIP_SHIFT) + 64'(BLEND_DIVISOR - 1)) / 64'(BLEND_DIVISOR));

    // Configuration registers.
    logic [COUNT_W-1:0]  measures_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic                enable_reg;

    // Tracking state.
    logic                learned_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [ADC_BITS-1:0] win_min_reg;
    logic [ADC_BITS-1:0] win_max_reg;
    logic [FIXED_W-1:0]  gmin_reg;
    logic [FIXED_W-1:0]  gmax_reg;

    // Working registers of the item in flight.
    logic [ADC_BITS-1:0] adc_reg;
    logic [ADC_BITS-1:0] fresh_min_reg;
    logic [ADC_BITS-1:0] fresh_max_reg;
    logic [ADC_BITS-1:0] lo_reg;
    logic [ADC_BITS-1:0] hi_reg;
    logic                ok_reg;
    logic                res_valid_reg;
    logic [SHIFT_W-1:0]  res_shift_reg;
    logic [SUM_W-1:0]    blend_sum_reg;

    // Output register.
    logic                m_valid_reg;
    logic                m_shift_valid_reg;
    logic [SHIFT_W-1:0]  m_shift_reg;
    logic [ADC_BITS-1:0] m_gate_low_reg;
    logic [ADC_BITS-1:0] m_gate_high_reg;

    logic [CMP_W-1:0]    adc_ext;
    logic [COUNT_W-1:0]  count_next;
    logic [COUNT_W-1:0]  limit;
    logic [ADC_BITS-1:0] win_min_next;
    logic [ADC_BITS-1:0] win_max_next;
    logic [ADC_BITS-1:0] gate_lo;
    logic [ADC_BITS-1:0] gate_hi_raw;
    logic [ADC_BITS-1:0] gate_hi;
    logic                gate_ok;
    logic [ADC_BITS-1:0] offset;
    logic [ADC_BITS-1:0] span;
    logic [PROD_W-1:0]   product;
    logic [SUM_W-1:0]    blend_sum;
    logic [BPROD_W-1:0]  blend_prod;
    logic [FIXED_W-1:0]  blend_quot;
    logic                div_done;
    logic [PROD_W-1:0]   div_quotient;

    assign adc_ext      = CMP_W'(adc_reg);
    assign count_next   = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign limit        = (measures_reg == '0) ? COUNT_W'(1) : measures_reg;
    assign win_min_next = (adc_reg < win_min_reg) ? adc_reg : win_min_reg;
    assign win_max_next = (adc_reg > win_max_reg) ? adc_reg : win_max_reg;

    assign gate_lo     = gmin_reg[FIXED_W-1:GATE_FRAC_BITS];
    assign gate_hi_raw = gmax_reg[FIXED_W-1:GATE_FRAC_BITS];
    assign gate_hi     = (gate_hi_raw >= ADC_BITS'(HIGH_GATE_MARGIN))
                       ? gate_hi_raw - ADC_BITS'(HIGH_GATE_MARGIN) : '0;
    assign gate_ok     = (adc_reg >= gate_lo) && (adc_reg <= gate_hi);

    assign offset  = adc_reg - lo_reg;
    assign span    = hi_reg - lo_reg;
    assign product = PROD_W'(offset) * PROD_W'(factor_reg);

    // Blend is (4*old + (window value << frac) + 2) / 5. The sum is registered
    // first, and the next cycle divides it by a reciprocal multiplication.
    always_comb begin
        unique case (cmd.blend_sel)
            BLEND_SEL_MIN: begin
                blend_sum = SUM_W'({gmin_reg, 2'b00})
                          + SUM_W'({fresh_min_reg, {GATE_FRAC_BITS{1'b0}}})
                          + SUM_W'(BLEND_ROUND);
            end
            BLEND_SEL_MAX: begin
                blend_sum = SUM_W'({gmax_reg, 2'b00})
                          + SUM_W'({fresh_max_reg, {GATE_FRAC_BITS{1'b0}}})
                          + SUM_W'(BLEND_ROUND);
            end
        endcase
    end

    assign blend_prod = BPROD_W'(blend_sum_reg) * BPROD_W'(BLEND_RECIP);
    assign blend_quot = blend_prod[RECIP_SHIFT +: FIXED_W];

    rsgt_div #(
        .DIVIDEND_W (PROD_W),
        .DIVISOR_W  (ADC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (product),
        .divisor  (span),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        stat.rejected = (adc_ext < CMP_W'(ACCEPT_LOW)) || (adc_ext > CMP_W'(ACCEPT_HIGH));
        stat.learned  = learned_reg;
        stat.at_limit = (count_next >= limit);
        stat.shift_ok = ok_reg && enable_reg && (hi_reg > lo_reg);
        stat.div_done = div_done;
        stat.out_free = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            measures_reg <= MEASURES_RESET;
            factor_reg   <= FACTOR_RESET;
            enable_reg   <= RANDOMIZE_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_MEASURES_PER_GATE: measures_reg <= cfg_data[COUNT_W-1:0];
                REG_INTERP_FACTOR:     factor_reg   <= cfg_data[FACTOR_W-1:0];
                REG_RANDOMIZE_ENABLE:  enable_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learned_reg <= 1'b0;
            count_reg   <= '0;
            win_min_reg <= '1;
            win_max_reg <= '0;
            gmin_reg    <= '0;
            gmax_reg    <= '0;
        end else begin
            if (cmd.win_latch || cmd.win_blend) begin
                count_reg   <= '0;
                win_min_reg <= '1;
                win_max_reg <= '0;
            end else if (cmd.win_update) begin
                count_reg   <= count_next;
                win_min_reg <= win_min_next;
                win_max_reg <= win_max_next;
            end
            if (cmd.win_latch) begin
                learned_reg <= 1'b1;
                gmin_reg    <= {win_min_next, {GATE_FRAC_BITS{1'b0}}};
                gmax_reg    <= {win_max_next, {GATE_FRAC_BITS{1'b0}}};
            end
            if (cmd.gmin_write) begin
                gmin_reg <= blend_quot;
            end
            if (cmd.gmax_write) begin
                gmax_reg <= blend_quot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            adc_reg <= s_adc_value;
        end
        if (cmd.win_blend) begin
            fresh_min_reg <= win_min_next;
            fresh_max_reg <= win_max_next;
        end
        if (cmd.blend_load) begin
            blend_sum_reg <= blend_sum;
        end
        if (cmd.reject) begin
            lo_reg <= '0;
            hi_reg <= '0;
            ok_reg <= 1'b0;
        end else if (cmd.first_gates) begin
            lo_reg <= win_min_next;
            hi_reg <= win_max_next;
            ok_reg <= 1'b1;
        end else if (cmd.gates_load) begin
            lo_reg <= gate_lo;
            hi_reg <= gate_hi;
            ok_reg <= gate_ok;
        end
        if (cmd.res_clear) begin
            res_valid_reg <= 1'b0;
            res_shift_reg <= '0;
        end else if (cmd.res_write) begin
            res_valid_reg <= 1'b1;
            res_shift_reg <= div_quotient[SHIFT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_shift_valid_reg <= res_valid_reg;
            m_shift_reg       <= res_shift_reg;
            m_gate_low_reg    <= lo_reg;
            m_gate_high_reg   <= hi_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_shift_valid = m_shift_valid_reg;
    assign m_shift       = m_shift_reg;
    assign m_gate_low    = m_gate_low_reg;
    assign m_gate_high   = m_gate_high_reg;

endmodule

// ===== rtl/core/rsgt_ctrl.sv =====
// Controller of the gate tracker: sequences one reading through window
// update, gate blending, gate check, shift division and result transfer.
// Depends on rsgt_pkg.
`timescale 1ns / 1ps

module rsgt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rsgt_pkg::rsgt_stat_t stat,
    output rsgt_pkg::rsgt_cmd_t  cmd
);

    import rsgt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_BMIN_SUM,
        ST_BMIN_WRITE,
        ST_BMAX_SUM,
        ST_BMAX_WRITE,
        ST_GATES,
        ST_SHIFT_GO,
        ST_SHIFT_WAIT,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;
    logic   s_ready_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture  = 1'b1;
                    s_ready_next = 1'b0;
                    state_next   = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.res_clear = 1'b1;
                priority if (stat.rejected) begin
                    cmd.reject = 1'b1;
                    state_next = ST_DONE;
                end else if (!stat.learned && !stat.at_limit) begin
                    cmd.win_update  = 1'b1;
                    cmd.first_gates = 1'b1;
                    state_next      = ST_SHIFT_GO;
                end else if (!stat.learned) begin
                    cmd.win_latch = 1'b1;
                    state_next    = ST_GATES;
                end else if (stat.at_limit) begin
                    cmd.win_blend = 1'b1;
                    state_next    = ST_BMIN_SUM;
                end else begin
                    cmd.win_update = 1'b1;
                    state_next     = ST_GATES;
                end
            end
            ST_BMIN_SUM: begin
                cmd.blend_load = 1'b1;
                cmd.blend_sel  = BLEND_SEL_MIN;
                state_next     = ST_BMIN_WRITE;
            end
            ST_BMIN_WRITE: begin
                cmd.gmin_write = 1'b1;
                state_next     = ST_BMAX_SUM;
            end
            ST_BMAX_SUM: begin
                cmd.blend_load = 1'b1;
                cmd.blend_sel  = BLEND_SEL_MAX;
                state_next     = ST_BMAX_WRITE;
            end
            ST_BMAX_WRITE: begin
                cmd.gmax_write = 1'b1;
                state_next     = ST_GATES;
            end
            ST_GATES: begin
                cmd.gates_load = 1'b1;
                state_next     = ST_SHIFT_GO;
            end
            ST_SHIFT_GO: begin
                if (stat.shift_ok) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_SHIFT_WAIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT_WAIT: begin
                if (stat.div_done) begin
                    cmd.res_write = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    s_ready_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

endmodule

// ===== rtl/core/random_sampling_gate_tracker_core.sv =====
// Path of a reading: the evaluation state, then for a rejected reading straight to the
// result; otherwise, except within the first window, the gates state, and if a shift can
// be formed the one-bit-per-cycle shift divider over the ADC_BITS + 6 (18 at defaults)
// bit product; a later window end adds the two gate blends. One reading is in work at a
// time; s_ready rises with m_valid when the result enters the output register, once free.
// Synchronous active-low reset clears gates, window state and output valid, and loads the configuration reset values.
`timescale 1ns / 1ps

module random_sampling_gate_tracker_core #(
    parameter int ADC_BITS       = rsgt_pkg::ADC_BITS_DEF,
    parameter int GATE_FRAC_BITS = rsgt_pkg::GATE_FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rsgt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsgt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ADC_BITS-1:0]             s_adc_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_shift_valid,
    output logic [rsgt_pkg::SHIFT_W-1:0]    m_shift,
    output logic [ADC_BITS-1:0]             m_gate_low,
    output logic [ADC_BITS-1:0]             m_gate_high
);

    import rsgt_pkg::*;

    rsgt_cmd_t  cmd;
    rsgt_stat_t stat;

    assign cfg_ready = 1'b1;

    rsgt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rsgt_datapath #(
        .ADC_BITS       (ADC_BITS),
        .GATE_FRAC_BITS (GATE_FRAC_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_adc_value   (s_adc_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_shift_valid (m_shift_valid),
        .m_shift       (m_shift),
        .m_gate_low    (m_gate_low),
        .m_gate_high   (m_gate_high)
    );

endmodule

// ===== rtl/core/rsgt_checker.sv =====
// Port-level checks for the gate tracker core, attached by bind.
// Depends on rsgt_pkg and random_sampling_gate_tracker_core.
`timescale 1ns / 1ps

module rsgt_checker #(
    parameter int ADC_BITS = rsgt_pkg::ADC_BITS_DEF
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_shift_valid,
    input logic [rsgt_pkg::SHIFT_W-1:0] m_shift,
    input logic [ADC_BITS-1:0]          m_gate_low,
    input logic [ADC_BITS-1:0]          m_gate_high
);

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_shift_valid) && $stable(m_shift)
            && $stable(m_gate_low) && $stable(m_gate_high))
    else $error("result changed while stalled");

    // A valid shift needs a nonzero span between the gates.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_shift_valid |-> m_gate_high > m_gate_low)
    else $error("valid shift with empty gate span");

    // The shift reads as zero whenever it is flagged invalid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_shift_valid |-> m_shift == '0)
    else $error("nonzero shift on invalid result");

    // Readings are worked one at a time, so a transfer closes the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
    else $error("input taken while a reading is in work");

endmodule

bind random_sampling_gate_tracker_core rsgt_checker #(
    .ADC_BITS (ADC_BITS)
) u_rsgt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_shift_valid (m_shift_valid),
    .m_shift       (m_shift),
    .m_gate_low    (m_gate_low),
    .m_gate_high   (m_gate_high)
);
